// ===== hdl/rmq_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and types of the rotation-matrix-to-quaternion converter.
// -----------------------------------------------------------------------------
package rmq_pkg;

    // Width that every component magnitude is scaled to before the squares
    localparam int NORM_BITS  = 30;
    // Bits of the integer square root of the sum of squares
    localparam int ROOT_BITS  = NORM_BITS + 1;
    // Sum of four squares of NORM_BITS-wide values
    localparam int SUMSQ_BITS = 2 * NORM_BITS + 2;

    // Branch that carries the trace term
    typedef logic [1:0] branch_t;
    localparam branch_t BR_X = 2'd0;
    localparam branch_t BR_Y = 2'd1;
    localparam branch_t BR_Z = 2'd2;
    localparam branch_t BR_W = 2'd3;

endpackage

// ===== hdl/rmq_mat_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rmq_mat_if
// Matrix channel: one 3x3 matrix word in signed fixed point, valid/ready.
// -----------------------------------------------------------------------------
interface rmq_mat_if #(
    parameter int W = 18
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] elem_00;
    logic signed [W-1:0] elem_01;
    logic signed [W-1:0] elem_02;
    logic signed [W-1:0] elem_10;
    logic signed [W-1:0] elem_11;
    logic signed [W-1:0] elem_12;
    logic signed [W-1:0] elem_20;
    logic signed [W-1:0] elem_21;
    logic signed [W-1:0] elem_22;

    modport source (
        output valid, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
               elem_20, elem_21, elem_22,
        input  ready
    );

    modport sink (
        input  valid, elem_00, elem_01, elem_02, elem_10, elem_11, elem_12,
               elem_20, elem_21, elem_22,
        output ready
    );
endinterface

// ===== hdl/rmq_quat_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rmq_quat_if
// Quaternion channel: one unit quaternion word plus a flag, valid/ready.
// -----------------------------------------------------------------------------
interface rmq_quat_if #(
    parameter int W = 18
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] quat_x;
    logic signed [W-1:0] quat_y;
    logic signed [W-1:0] quat_z;
    logic signed [W-1:0] quat_w;
    logic                not_rotation;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, not_rotation,
        input  ready
    );

    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, not_rotation,
        output ready
    );
endinterface

// ===== hdl/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed Q1.FRAC_BITS into a unit quaternion.
// -----------------------------------------------------------------------------
// Usage:
//   matrix (sink)  : one word holds the nine elements m(0,0)..m(2,2), each
//                    FRAC_BITS+2 bits, 1.0 = 2^FRAC_BITS.
//   quat (source)  : one word holds x, y, z, w of the unit quaternion in the
//                    same format, plus not_rotation. When the trace term of
//                    the chosen branch is not positive, the components are
//                    zero and not_rotation is high.
//   Pipeline       : five front stages, one stage per root bit of the
//                    31-step square root, one setup stage, one stage per
//                    quotient bit of the four parallel restoring dividers,
//                    and the output register.
//   Throughput     : one word per cycle while the receiver does not stall;
//                    every unit is fully pipelined.
//   Reset          : clears all stage valid bits; the pipeline comes up empty.
//   Stall          : when the receiver holds ready low with a word waiting,
//                    the whole pipeline holds and matrix.ready drops in the
//                    same cycle; nothing is lost or repeated. Bubbles flow
//                    normally while the output register is empty or taken.
// -----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rmq_mat_if.sink   matrix,
    rmq_quat_if.source quat
);
    import rmq_pkg::*;

    localparam int W    = FRAC_BITS + 2;        // field width
    localparam int QW   = FRAC_BITS + 4;        // signed trace/component width
    localparam int MW   = FRAC_BITS + 3;        // component magnitude width
    localparam int LW   = $clog2(MW + 1);       // bit length width
    localparam int NB   = NORM_BITS;
    localparam int SW   = SUMSQ_BITS;
    localparam int RB   = ROOT_BITS;
    localparam int REMW = RB + 2;               // square root remainder
    localparam int NW   = NB + FRAC_BITS + 1;   // rounded dividend
    localparam int QB   = FRAC_BITS + 1;        // quotient bits
    localparam int DRW  = RB + 1;               // divider remainder

    localparam logic signed [QW-1:0] ONE_Q  = {{(QW-FRAC_BITS-1){1'b0}}, 1'b1,
                                               {FRAC_BITS{1'b0}}};
    localparam logic [QB-1:0]        ONE_QB = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [W-1:0]  ONE_W  = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic signed [W-1:0]  NEG_ONE_W = {2'b11, {FRAC_BITS{1'b0}}};

    // Global advance: move every stage when the output word is gone or taken
    logic adv;
    logic out_valid_reg;
    assign adv          = !out_valid_reg || quat.ready;
    assign matrix.ready = adv;

    // ------------------------------------------------------------------
    // Stage A: pick the branch, form the trace term and the raw quaternion
    // ------------------------------------------------------------------
    logic signed [QW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [QW-1:0] a_t_next;
    logic signed [QW-1:0] a_q_next [4];
    logic signed [QW-1:0] a_q_reg  [4];
    logic                 a_flag_reg;
    logic                 a_valid_reg;
    branch_t              a_br;

    assign m00 = QW'(matrix.elem_00);
    assign m01 = QW'(matrix.elem_01);
    assign m02 = QW'(matrix.elem_02);
    assign m10 = QW'(matrix.elem_10);
    assign m11 = QW'(matrix.elem_11);
    assign m12 = QW'(matrix.elem_12);
    assign m20 = QW'(matrix.elem_20);
    assign m21 = QW'(matrix.elem_21);
    assign m22 = QW'(matrix.elem_22);

    always_comb
    begin
        if (m22 < 0)
        begin
            a_br = (m00 > m11) ? BR_X : BR_Y;
        end
        else
        begin
            a_br = (m00 + m11 < 0) ? BR_Z : BR_W;
        end
        case (a_br)
            BR_X:
            begin
                a_t_next    = ONE_Q + m00 - m11 - m22;
                a_q_next[0] = a_t_next;
                a_q_next[1] = m01 + m10;
                a_q_next[2] = m20 + m02;
                a_q_next[3] = m12 - m21;
            end
            BR_Y:
            begin
                a_t_next    = ONE_Q - m00 + m11 - m22;
                a_q_next[0] = m01 + m10;
                a_q_next[1] = a_t_next;
                a_q_next[2] = m12 + m21;
                a_q_next[3] = m20 - m02;
            end
            BR_Z:
            begin
                a_t_next    = ONE_Q - m00 - m11 + m22;
                a_q_next[0] = m20 + m02;
                a_q_next[1] = m12 + m21;
                a_q_next[2] = a_t_next;
                a_q_next[3] = m01 - m10;
            end
            default:
            begin
                a_t_next    = ONE_Q + m00 + m11 + m22;
                a_q_next[0] = m12 - m21;
                a_q_next[1] = m20 - m02;
                a_q_next[2] = m01 - m10;
                a_q_next[3] = a_t_next;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= matrix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_q_reg    <= a_q_next;
            a_flag_reg <= (a_t_next <= 0);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: magnitudes, signs and bit length of the largest magnitude
    // ------------------------------------------------------------------
    logic [MW-1:0] b_mag_next [4];
    logic [MW-1:0] b_mag_reg  [4];
    logic [3:0]    b_sign_next;
    logic [3:0]    b_sign_reg;
    logic [MW-1:0] b_or;
    logic [LW-1:0] b_len_next;
    logic [LW-1:0] b_len_reg;
    logic          b_flag_reg;
    logic          b_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            b_sign_next[i] = a_q_reg[i][QW-1];
            b_mag_next[i]  = b_sign_next[i] ? MW'(-a_q_reg[i]) : MW'(a_q_reg[i]);
        end
        // Bit length of the OR equals that of the maximum
        b_or = b_mag_next[0] | b_mag_next[1] | b_mag_next[2] | b_mag_next[3];
        b_len_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (b_or[i])
            begin
                b_len_next = LW'(i + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_mag_reg  <= b_mag_next;
            b_sign_reg <= b_sign_next;
            b_len_reg  <= b_len_next;
            b_flag_reg <= a_flag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: scale so the largest magnitude spans NORM_BITS bits
    // ------------------------------------------------------------------
    logic [NB-1:0]    c_b_next [4];
    logic [NB-1:0]    c_b_reg  [4];
    logic [MW+NB-1:0] c_wide   [4];
    logic [3:0]       c_sign_reg;
    logic             c_flag_reg;
    logic             c_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            c_wide[i]   = {b_mag_reg[i], {NB{1'b0}}} >> b_len_reg;
            c_b_next[i] = c_wide[i][NB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_b_reg    <= c_b_next;
            c_sign_reg <= b_sign_reg;
            c_flag_reg <= b_flag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: four squares
    // ------------------------------------------------------------------
    logic [2*NB-1:0] d_sq_reg [4];
    logic [NB-1:0]   d_b_reg  [4];
    logic [3:0]      d_sign_reg;
    logic            d_flag_reg;
    logic            d_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                d_sq_reg[i] <= c_b_reg[i] * c_b_reg[i];
            end
            d_b_reg    <= c_b_reg;
            d_sign_reg <= c_sign_reg;
            d_flag_reg <= c_flag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: sum of squares
    // ------------------------------------------------------------------
    logic [SW-1:0] e_s_reg;
    logic [NB-1:0] e_b_reg [4];
    logic [3:0]    e_sign_reg;
    logic          e_flag_reg;
    logic          e_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_s_reg    <= SW'(d_sq_reg[0]) + SW'(d_sq_reg[1])
                        + SW'(d_sq_reg[2]) + SW'(d_sq_reg[3]);
            e_b_reg    <= d_b_reg;
            e_sign_reg <= d_sign_reg;
            e_flag_reg <= d_flag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage, two radicand bits consumed each
    // ------------------------------------------------------------------
    logic [REMW-1:0] sq_rem_reg  [RB];
    logic [RB-1:0]   sq_root_reg [RB];
    logic [SW-1:0]   sq_s_reg    [RB];
    logic [NB-1:0]   sq_b_reg    [RB][4];
    logic [3:0]      sq_sign_reg [RB];
    logic [RB-1:0]   sq_flag_reg;
    logic [RB-1:0]   sq_valid_reg;

    for (genvar j = 0; j < RB; j++)
    begin : g_sqrt
        logic [REMW-1:0] rem_in, rem_sh, trial, rem_next;
        logic [RB-1:0]   root_in, root_next;
        logic [SW-1:0]   s_in;
        logic [NB-1:0]   b_in [4];
        logic [3:0]      sign_in;
        logic            flag_in;
        logic            valid_in;

        if (j == 0)
        begin : g_first
            assign rem_in   = '0;
            assign root_in  = '0;
            assign s_in     = e_s_reg;
            assign b_in     = e_b_reg;
            assign sign_in  = e_sign_reg;
            assign flag_in  = e_flag_reg;
            assign valid_in = e_valid_reg;
        end
        else
        begin : g_next
            assign rem_in   = sq_rem_reg[j-1];
            assign root_in  = sq_root_reg[j-1];
            assign s_in     = sq_s_reg[j-1];
            assign b_in     = sq_b_reg[j-1];
            assign sign_in  = sq_sign_reg[j-1];
            assign flag_in  = sq_flag_reg[j-1];
            assign valid_in = sq_valid_reg[j-1];
        end

        assign rem_sh = {rem_in[REMW-3:0], s_in[2*(RB-1-j)+1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_comb
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[RB-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[j]  <= rem_next;
                sq_root_reg[j] <= root_next;
                sq_s_reg[j]    <= s_in;
                sq_b_reg[j]    <= b_in;
                sq_sign_reg[j] <= sign_in;
                sq_flag_reg[j] <= flag_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: rounded dividends b << FRAC_BITS + r/2
    // ------------------------------------------------------------------
    logic [RB-1:0] n_root;
    logic [NW-1:0] n_num_reg [4];
    logic [RB-1:0] n_r_reg;
    logic [3:0]    n_sign_reg;
    logic          n_flag_reg;
    logic          n_valid_reg;

    assign n_root = (sq_root_reg[RB-1] == '0) ? RB'(1) : sq_root_reg[RB-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            n_valid_reg <= sq_valid_reg[RB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                n_num_reg[i] <= {1'b0, sq_b_reg[RB-1][i], {FRAC_BITS{1'b0}}}
                              + NW'(n_root >> 1);
            end
            n_r_reg    <= n_root;
            n_sign_reg <= sq_sign_reg[RB-1];
            n_flag_reg <= sq_flag_reg[RB-1];
        end
    end

    // ------------------------------------------------------------------
    // Four restoring dividers, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [DRW-1:0] dv_rem_reg  [QB][4];
    logic [QB-1:0]  dv_quo_reg  [QB][4];
    logic [NW-1:0]  dv_num_reg  [QB][4];
    logic [RB-1:0]  dv_r_reg    [QB];
    logic [3:0]     dv_sign_reg [QB];
    logic [QB-1:0]  dv_flag_reg;
    logic [QB-1:0]  dv_valid_reg;

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [DRW-1:0] rem_in   [4];
        logic [DRW-1:0] rem_sh   [4];
        logic [DRW-1:0] rem_next [4];
        logic [QB-1:0]  quo_in   [4];
        logic [QB-1:0]  quo_next [4];
        logic [NW-1:0]  num_in   [4];
        logic [RB-1:0]  r_in;
        logic [3:0]     sign_in;
        logic           flag_in;
        logic           valid_in;

        if (k == 0)
        begin : g_first
            for (genvar i = 0; i < 4; i++)
            begin : g_lane
                assign rem_in[i] = DRW'(n_num_reg[i][NW-1 -: NB]);
                assign quo_in[i] = '0;
            end
            assign num_in   = n_num_reg;
            assign r_in     = n_r_reg;
            assign sign_in  = n_sign_reg;
            assign flag_in  = n_flag_reg;
            assign valid_in = n_valid_reg;
        end
        else
        begin : g_next
            assign rem_in   = dv_rem_reg[k-1];
            assign quo_in   = dv_quo_reg[k-1];
            assign num_in   = dv_num_reg[k-1];
            assign r_in     = dv_r_reg[k-1];
            assign sign_in  = dv_sign_reg[k-1];
            assign flag_in  = dv_flag_reg[k-1];
            assign valid_in = dv_valid_reg[k-1];
        end

        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                rem_sh[i] = {rem_in[i][DRW-2:0], num_in[i][FRAC_BITS-k]};
                if (rem_sh[i] >= {1'b0, r_in})
                begin
                    rem_next[i] = rem_sh[i] - {1'b0, r_in};
                    quo_next[i] = {quo_in[i][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = rem_sh[i];
                    quo_next[i] = {quo_in[i][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[k]  <= rem_next;
                dv_quo_reg[k]  <= quo_next;
                dv_num_reg[k]  <= num_in;
                dv_r_reg[k]    <= r_in;
                dv_sign_reg[k] <= sign_in;
                dv_flag_reg[k] <= flag_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: clamp, restore the sign, zero a non-rotation
    // ------------------------------------------------------------------
    logic [QB-1:0]       o_mag  [4];
    logic signed [W-1:0] o_next [4];
    logic signed [W-1:0] o_reg  [4];
    logic                o_flag_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            o_mag[i] = (dv_quo_reg[QB-1][i] > ONE_QB) ? ONE_QB : dv_quo_reg[QB-1][i];
            if (dv_flag_reg[QB-1])
            begin
                o_next[i] = '0;
            end
            else if (dv_sign_reg[QB-1][i])
            begin
                o_next[i] = -$signed({1'b0, o_mag[i]});
            end
            else
            begin
                o_next[i] = $signed({1'b0, o_mag[i]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_reg      <= o_next;
            o_flag_reg <= dv_flag_reg[QB-1];
        end
    end

    assign quat.valid        = out_valid_reg;
    assign quat.quat_x       = o_reg[0];
    assign quat.quat_y       = o_reg[1];
    assign quat.quat_z       = o_reg[2];
    assign quat.quat_w       = o_reg[3];
    assign quat.not_rotation = o_flag_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A non-rotation word carries all-zero components
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid && quat.not_rotation |->
            quat.quat_x == '0 && quat.quat_y == '0 &&
            quat.quat_z == '0 && quat.quat_w == '0)
        else $error("non-rotation word with nonzero components");

    // Every unit component stays within plus or minus one
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid |->
            quat.quat_x <= ONE_W && quat.quat_x >= NEG_ONE_W &&
            quat.quat_y <= ONE_W && quat.quat_y >= NEG_ONE_W &&
            quat.quat_z <= ONE_W && quat.quat_z >= NEG_ONE_W &&
            quat.quat_w <= ONE_W && quat.quat_w >= NEG_ONE_W)
        else $error("quaternion component out of range");

    // The divisor handed to the dividers is never zero
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        n_valid_reg |-> n_r_reg != '0)
        else $error("zero divisor entering dividers");

    // A held output word keeps its x component and flag, and stays valid, while the pipeline is frozen
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(o_reg[0]) && $stable(o_flag_reg) && out_valid_reg)
        else $error("output word changed during stall");

endmodule

// ===== sim/tb_rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Self-checking bench for the matrix-to-quaternion converter.
// -----------------------------------------------------------------------------
// A queue of matrix words, filled by the stimulus process, feeds a clocked
// driver. A clocked monitor picks up every quaternion word and compares it
// field by field against the prediction made when the matrix word was taken.
// The run walks through idle phases (none, sender gaps, receiver stalls,
// both), one long receiver hold-off and full drains between phases, then reports.
// -----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;

    localparam int FB      = 16;
    localparam int W       = FB + 2;
    localparam int LAT     = FB + 39;
    localparam int LIMIT   = 400000;
    localparam int N_RAND  = 1930;

    typedef logic signed [W-1:0] fx_t;

    typedef struct {
        fx_t m [9];
    } mat_word_t;

    typedef struct {
        fx_t  q [4];
        logic bad;
    } quat_word_t;

    logic clk;
    logic rst_n;

    rmq_mat_if  #(.W(W)) mat_ch ();
    rmq_quat_if #(.W(W)) quat_ch ();

    rotation_matrix_to_quaternion #(.FRAC_BITS(FB)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .matrix (mat_ch.sink),
        .quat   (quat_ch.source)
    );

    mat_word_t  pending_mats [$];
    quat_word_t expected_quats [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit recv_hold      = 0;
    int hold_cycles    = 0;
    int n_errors       = 0;
    int n_checked      = 0;
    int n_not_rot      = 0;
    longint cycle_cnt  = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Integer square root, bit by bit
    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Branch choice, trace term and normalisation to a unit quaternion
    function automatic quat_word_t predict_quat(input mat_word_t mw);
        quat_word_t      r;
        longint          e [9];
        longint          q [4];
        longint          t;
        longint          one;
        longint unsigned mag [4];
        longint unsigned mx;
        longint unsigned ss;
        longint unsigned rt;
        longint unsigned o;
        int              len;
        one = longint'(1) << FB;
        for (int i = 0; i < 9; i++) e[i] = longint'(mw.m[i]);
        if (e[8] < 0)
        begin
            if (e[0] > e[4])
            begin
                t = one + e[0] - e[4] - e[8];
                q = '{t, e[1] + e[3], e[6] + e[2], e[5] - e[7]};
            end
            else
            begin
                t = one - e[0] + e[4] - e[8];
                q = '{e[1] + e[3], t, e[5] + e[7], e[6] - e[2]};
            end
        end
        else if (e[0] + e[4] < 0)
        begin
            t = one - e[0] - e[4] + e[8];
            q = '{e[6] + e[2], e[5] + e[7], t, e[1] - e[3]};
        end
        else
        begin
            t = one + e[0] + e[4] + e[8];
            q = '{e[5] - e[7], e[6] - e[2], e[1] - e[3], t};
        end
        r.bad = (t <= 0);
        for (int i = 0; i < 4; i++) r.q[i] = '0;
        if (r.bad) return r;
        mx = 0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = (q[i] < 0) ? longint'(-q[i]) : q[i];
            if (mag[i] > mx) mx = mag[i];
        end
        len = 0;
        while (mx != 0)
        begin
            len++;
            mx >>= 1;
        end
        ss = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (len > rmq_pkg::NORM_BITS) mag[i] >>= (len - rmq_pkg::NORM_BITS);
            else mag[i] <<= (rmq_pkg::NORM_BITS - len);
            ss += mag[i] * mag[i];
        end
        rt = int_sqrt(ss);
        if (rt == 0) rt = 1;
        for (int i = 0; i < 4; i++)
        begin
            o = ((mag[i] << FB) + (rt >> 1)) / rt;
            if (o > (64'd1 << FB)) o = 64'd1 << FB;
            r.q[i] = (q[i] < 0) ? fx_t'(-longint'(o)) : fx_t'(o);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch @%0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
        n_errors++;
    endtask

    function automatic fx_t rand_elem();
        case ($urandom_range(0, 5))
            0: return fx_t'($urandom);                      // any bit pattern
            1: return fx_t'(-(1 << FB));
            2: return fx_t'(1 << FB);
            default: return fx_t'(int'($urandom_range(0, 2 << FB)) - (1 << FB));
        endcase
    endfunction

    // Orthonormal-ish matrix from a random quaternion, so branches follow real poses
    function automatic mat_word_t rand_rotation();
        mat_word_t mw;
        real a, b, c, d, n;
        a = real'($urandom_range(0, 2000)) - 1000.0;
        b = real'($urandom_range(0, 2000)) - 1000.0;
        c = real'($urandom_range(0, 2000)) - 1000.0;
        d = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(a*a + b*b + c*c + d*d);
        if (n == 0.0)
        begin
            d = 1.0;
            n = 1.0;
        end
        a /= n; b /= n; c /= n; d /= n;
        mw.m[0] = fx_t'($rtoi((1.0 - 2.0*(b*b + c*c)) * 65536.0));
        mw.m[1] = fx_t'($rtoi(2.0*(a*b + c*d) * 65536.0));
        mw.m[2] = fx_t'($rtoi(2.0*(a*c - b*d) * 65536.0));
        mw.m[3] = fx_t'($rtoi(2.0*(a*b - c*d) * 65536.0));
        mw.m[4] = fx_t'($rtoi((1.0 - 2.0*(a*a + c*c)) * 65536.0));
        mw.m[5] = fx_t'($rtoi(2.0*(b*c + a*d) * 65536.0));
        mw.m[6] = fx_t'($rtoi(2.0*(a*c + b*d) * 65536.0));
        mw.m[7] = fx_t'($rtoi(2.0*(b*c - a*d) * 65536.0));
        mw.m[8] = fx_t'($rtoi((1.0 - 2.0*(a*a + b*b)) * 65536.0));
        return mw;
    endfunction

    task automatic push_diag(input int d0, input int d1, input int d2, input int off);
        mat_word_t mw;
        for (int i = 0; i < 9; i++) mw.m[i] = fx_t'(off);
        mw.m[0] = fx_t'(d0);
        mw.m[4] = fx_t'(d1);
        mw.m[8] = fx_t'(d2);
        pending_mats.insert(pending_mats.size(), mw);
    endtask

    task automatic push_random(input int n);
        for (int k = 0; k < n; k++)
        begin
            mat_word_t mw;
            if ($urandom_range(0, 99) < 70) mw = rand_rotation();
            else for (int i = 0; i < 9; i++) mw.m[i] = rand_elem();
            pending_mats.insert(pending_mats.size(), mw);
        end
    endtask

    task automatic wait_drained();
        while (pending_mats.size() != 0 || mat_ch.valid || expected_quats.size() != 0)
            @(posedge clk);
    endtask

    // Driver: offer the head of the queue; advance on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mat_ch.valid <= 1'b0;
        else
        begin
            if (!mat_ch.valid || mat_ch.ready)
            begin
                if (mat_ch.valid && mat_ch.ready)
                    expected_quats.insert(expected_quats.size(),
                                          predict_quat(pending_mats.pop_front()));
                if (pending_mats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    mat_ch.valid   <= 1'b1;
                    mat_ch.elem_00 <= pending_mats[0].m[0];
                    mat_ch.elem_01 <= pending_mats[0].m[1];
                    mat_ch.elem_02 <= pending_mats[0].m[2];
                    mat_ch.elem_10 <= pending_mats[0].m[3];
                    mat_ch.elem_11 <= pending_mats[0].m[4];
                    mat_ch.elem_12 <= pending_mats[0].m[5];
                    mat_ch.elem_20 <= pending_mats[0].m[6];
                    mat_ch.elem_21 <= pending_mats[0].m[7];
                    mat_ch.elem_22 <= pending_mats[0].m[8];
                end
                else
                    mat_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: check every taken word, then pick next cycle's ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quat_ch.ready <= 1'b0;
        else
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (quat_ch.valid && quat_ch.ready)
            begin
                if (expected_quats.size() == 0)
                    report_mismatch("word with nothing expected", 0, 0);
                else
                begin
                    quat_word_t ex;
                    ex = expected_quats.pop_front();
                    n_checked++;
                    if (ex.bad) n_not_rot++;
                    if (quat_ch.quat_x !== ex.q[0])
                        report_mismatch("quat_x", quat_ch.quat_x, ex.q[0]);
                    if (quat_ch.quat_y !== ex.q[1])
                        report_mismatch("quat_y", quat_ch.quat_y, ex.q[1]);
                    if (quat_ch.quat_z !== ex.q[2])
                        report_mismatch("quat_z", quat_ch.quat_z, ex.q[2]);
                    if (quat_ch.quat_w !== ex.q[3])
                        report_mismatch("quat_w", quat_ch.quat_w, ex.q[3]);
                    if (quat_ch.not_rotation !== ex.bad)
                        report_mismatch("not_rotation", quat_ch.not_rotation, ex.bad);
                end
            end
            if (recv_hold)
                quat_ch.ready <= 1'b0;
            else
                quat_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Count the cycles of a receiver hold-off
    always @(posedge clk)
    begin
        if (recv_hold)
            hold_cycles <= hold_cycles + 1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycle_cnt > LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: identity, each branch, half turns, extremes, non-rotations
        push_diag(1 << FB, 1 << FB, 1 << FB, 0);          // identity, w branch
        push_diag(1 << FB, -(1 << FB), -(1 << FB), 0);    // x branch
        push_diag(-(1 << FB), 1 << FB, -(1 << FB), 0);    // y branch
        push_diag(-(1 << FB), -(1 << FB), 1 << FB, 0);    // z branch
        push_diag(0, 0, -1, 0);                           // m22 just negative, tie
        push_diag(-1, 0, 0, 0);                           // diagonal sum just negative
        push_diag(-(1 << FB), -(1 << FB), -(1 << FB), 0); // trace not positive
        push_diag(-(2 << FB), 0, 0, 0);                   // z branch, trace term positive, flag clear
        push_diag(-(2 << FB), -(2 << FB), -(2 << FB), 0); // most negative diagonal fields
        push_diag((2 << FB) - 1, (2 << FB) - 1, (2 << FB) - 1, (2 << FB) - 1);
        push_diag((2 << FB) - 1, -(2 << FB), -(2 << FB), -(2 << FB));
        push_diag(0, 0, 0, -(2 << FB));
        push_diag(0, 0, 0, (2 << FB) - 1);
        push_diag(0, 0, 0, 0);
        push_diag(1, -(2 << FB), 5, 1 << FB);
        push_diag(-(1 << FB), (1 << FB) - 1, -(1 << FB), 3);
        wait_drained();

        // Random phases with different idle mixes
        send_idle_pct = 0;  recv_stall_pct = 0;  push_random(500); wait_drained();
        send_idle_pct = 71; recv_stall_pct = 0;  push_random(350); wait_drained();
        send_idle_pct = 0;  recv_stall_pct = 71; push_random(350); wait_drained();
        send_idle_pct = 26; recv_stall_pct = 26; push_random(330);

        // Long receiver hold-off while the sender keeps offering
        recv_hold = 1'b1;
        while (hold_cycles < 3 * LAT) @(posedge clk);
        recv_hold = 1'b0;
        wait_drained();

        // Sender pauses for a full drain, then a final burst
        send_idle_pct = 0; recv_stall_pct = 0;
        push_random(N_RAND - 1530);
        wait_drained();
        repeat (LAT + 10) @(posedge clk);

        $display("checked %0d quaternion words (%0d flagged as not a rotation)",
                 n_checked, n_not_rot);
        $display("idle mixes: none, sender gaps, receiver stalls, both; one long hold-off");
        if (n_errors == 0 && expected_quats.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rmq_pkg.sv
hdl/rmq_mat_if.sv
hdl/rmq_quat_if.sv
hdl/rotation_matrix_to_quaternion.sv
sim/tb_rotation_matrix_to_quaternion.sv
